// ===== rtl/core/ffsa_pkg.sv =====
`timescale 1ns / 1ps

package ffsa_pkg;

    localparam int UNIT_W   = 10;
    localparam int OWNER_W  = 16;
    localparam int REQ_W    = 8;
    localparam int BASE_O_W = 9;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } status_t;

    typedef struct packed {
        logic [UNIT_W-1:0]  base;
        logic [UNIT_W-1:0]  size;
        logic [OWNER_W-1:0] owner;
        logic               used;
    } seg_entry_t;

    localparam int ENTRY_W = $bits(seg_entry_t);

endpackage

// ===== rtl/core/ffsa_ram.sv =====
`timescale 1ns / 1ps

module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/first_fit_segment_allocator_core.sv =====
`timescale 1ns / 1ps

// First-fit segment allocator. An address-ordered table of segments (base, size,
// owner, used) lives in one RAM of MAX_SEGMENTS entries with a registered read.
// Each input transaction (allocate or free, selected by s_tuser) produces exactly
// one result transaction carrying a status and a base address. One transaction
// is handled at a time: the search reads and then checks each table entry it
// visits; an allocate that splits a segment then moves every entry above the
// hit one place up (read, then write) and writes the two halves of the split; a
// free reads and checks its neighbours, and one that merges moves every entry
// above the gap one place down (read, then write). The longest case is a free
// near the bottom of a full table that merges on both sides, as every move goes
// through the single RAM port pair. After reset, and after every memory_size
// write, the S_INIT state rebuilds the table as a single free segment; no input
// is taken in that state. memory_size writes must only be issued while the block
// is idle. A new input may be taken while the previous result still waits on the
// output register.

module first_fit_segment_allocator_core
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int MEM_UNITS    = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: memory_size
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,
    // input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] owner_id, [23:16] request_size
    input  logic        s_tuser,   // [0] action
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [10:2] base_address
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [UNIT_W-1:0] RESET_SIZE =
        (MEM_UNITS < 512) ? UNIT_W'(MEM_UNITS) : UNIT_W'(512);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD, S_CHK,
        S_UP_RD, S_UP_WR, S_SPLIT, S_SPLIT2,
        S_NX_RD, S_NX_CHK, S_PV, S_PV_CHK, S_WB,
        S_DN_RD, S_DN_WR, S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [UNIT_W-1:0]  msize_reg, msize_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      j_reg, j_next;
    logic               phase_reg, phase_next;
    logic               action_reg, action_next;
    logic [OWNER_W-1:0] owner_reg, owner_next;
    logic [REQ_W-1:0]   req_reg, req_next;
    seg_entry_t         ent_reg, ent_next;
    logic [UNIT_W-1:0]  cur_size_reg, cur_size_next;
    status_t            status_reg, status_next;
    logic [UNIT_W-1:0]  base_reg, base_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [BASE_O_W-1:0] m_base_reg, m_base_next;

    logic               ram_we;
    logic [CW-1:0]      ram_waddr, ram_raddr;
    seg_entry_t         ram_wdata, rd;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [UNIT_W-1:0]  req_ext;
    logic [UNIT_W-1:0]  cfg_sat;
    logic [CW:0]        pos_p2;
    logic               hit;

    ffsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd      = seg_entry_t'(ram_rdata);
    assign req_ext = UNIT_W'(req_reg);
    assign pos_p2  = {1'b0, pos_reg} + (CW+1)'(2);
    assign hit     = (action_reg == ACT_ALLOC) ? (!rd.used && rd.size >= req_ext)
                                               : (rd.used && rd.owner == owner_reg);

    // saturate the written size into 1..MEM_UNITS
    always_comb begin
        cfg_sat = cfg_wr_data;
        if (cfg_wr_data == '0) begin
            cfg_sat = UNIT_W'(1);
        end else if (32'(cfg_wr_data) > 32'(MEM_UNITS)) begin
            cfg_sat = UNIT_W'(MEM_UNITS);
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_base_reg, m_status_reg};

    always_comb begin
        state_next    = state_reg;
        msize_next    = msize_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        j_next        = j_reg;
        phase_next    = phase_reg;
        action_next   = action_reg;
        owner_next    = owner_reg;
        req_next      = req_reg;
        ent_next      = ent_reg;
        cur_size_next = cur_size_reg;
        status_next   = status_reg;
        base_next     = base_reg;
        m_status_next = m_status_reg;
        m_base_next   = m_base_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;

        unique case (state_reg)
            S_INIT: begin
                // rebuild the table as one free segment
                ram_we         = 1'b1;
                ram_wdata.size = msize_reg;
                count_next     = CW'(1);
                state_next     = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    action_next = s_tuser;
                    owner_next  = s_tdata[15:0];
                    req_next    = s_tdata[23:16];
                    idx_next    = '0;
                    state_next  = S_RD;
                end
            end
            S_RD: begin
                ram_raddr  = idx_reg;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (hit) begin
                    ent_next      = rd;
                    pos_next      = idx_reg;
                    base_next     = rd.base;
                    cur_size_next = rd.size;
                    status_next   = ST_OK;
                    if (action_reg == ACT_ALLOC) begin
                        if (req_ext == rd.size) begin
                            // exact fit: mark in place
                            ram_we          = 1'b1;
                            ram_waddr       = idx_reg;
                            ram_wdata       = rd;
                            ram_wdata.owner = owner_reg;
                            ram_wdata.used  = 1'b1;
                            state_next      = S_DONE;
                        end else if (32'(count_reg) >= 32'(MAX_SEGMENTS)) begin
                            status_next = ST_TABLE_FULL;
                            state_next  = S_DONE;
                        end else if (idx_reg + CW'(1) < count_reg) begin
                            j_next     = count_reg - CW'(1);
                            state_next = S_UP_RD;
                        end else begin
                            state_next = S_SPLIT;
                        end
                    end else begin
                        if (idx_reg + CW'(1) < count_reg) begin
                            state_next = S_NX_RD;
                        end else begin
                            state_next = S_PV;
                        end
                    end
                end else if (idx_reg + CW'(1) < count_reg) begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_RD;
                end else begin
                    status_next = (action_reg == ACT_ALLOC) ? ST_NO_SPACE : ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end
            S_UP_RD: begin
                ram_raddr  = j_reg;
                state_next = S_UP_WR;
            end
            S_UP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = j_reg + CW'(1);
                ram_wdata = rd;
                if (j_reg == pos_reg + CW'(1)) begin
                    state_next = S_SPLIT;
                end else begin
                    j_next     = j_reg - CW'(1);
                    state_next = S_UP_RD;
                end
            end
            S_SPLIT: begin
                ram_we         = 1'b1;
                ram_waddr      = pos_reg + CW'(1);
                ram_wdata.base = ent_reg.base + req_ext;
                ram_wdata.size = ent_reg.size - req_ext;
                state_next     = S_SPLIT2;
            end
            S_SPLIT2: begin
                ram_we          = 1'b1;
                ram_waddr       = pos_reg;
                ram_wdata.base  = ent_reg.base;
                ram_wdata.size  = req_ext;
                ram_wdata.owner = owner_reg;
                ram_wdata.used  = 1'b1;
                count_next      = count_reg + CW'(1);
                state_next      = S_DONE;
            end
            S_NX_RD: begin
                ram_raddr  = pos_reg + CW'(1);
                state_next = S_NX_CHK;
            end
            S_NX_CHK: begin
                if (!rd.used) begin
                    // absorb the next segment, close the gap above it
                    cur_size_next = cur_size_reg + rd.size;
                    if (pos_p2 < {1'b0, count_reg}) begin
                        j_next     = pos_p2[CW-1:0];
                        phase_next = 1'b0;
                        state_next = S_DN_RD;
                    end else begin
                        count_next = count_reg - CW'(1);
                        state_next = S_PV;
                    end
                end else begin
                    state_next = S_PV;
                end
            end
            S_PV: begin
                if (pos_reg != '0) begin
                    ram_raddr  = pos_reg - CW'(1);
                    state_next = S_PV_CHK;
                end else begin
                    state_next = S_WB;
                end
            end
            S_PV_CHK: begin
                if (!rd.used) begin
                    ram_we         = 1'b1;
                    ram_waddr      = pos_reg - CW'(1);
                    ram_wdata.base = rd.base;
                    ram_wdata.size = rd.size + cur_size_reg;
                    if (pos_reg + CW'(1) < count_reg) begin
                        j_next     = pos_reg + CW'(1);
                        phase_next = 1'b1;
                        state_next = S_DN_RD;
                    end else begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end
                end else begin
                    state_next = S_WB;
                end
            end
            S_WB: begin
                ram_we         = 1'b1;
                ram_waddr      = pos_reg;
                ram_wdata.base = ent_reg.base;
                ram_wdata.size = cur_size_reg;
                state_next     = S_DONE;
            end
            S_DN_RD: begin
                ram_raddr  = j_reg;
                state_next = S_DN_WR;
            end
            S_DN_WR: begin
                ram_we    = 1'b1;
                ram_waddr = j_reg - CW'(1);
                ram_wdata = rd;
                if (j_reg + CW'(1) == count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = phase_reg ? S_DONE : S_PV;
                end else begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_DN_RD;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_base_next   = (status_reg == ST_OK) ? base_reg[BASE_O_W-1:0] : '0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase

        if (cfg_wr_en) begin
            msize_next = cfg_sat;
            state_next = S_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            msize_reg   <= RESET_SIZE;
            count_reg   <= CW'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            msize_reg   <= msize_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        j_reg        <= j_next;
        phase_reg    <= phase_next;
        action_reg   <= action_next;
        owner_reg    <= owner_next;
        req_reg      <= req_next;
        ent_reg      <= ent_next;
        cur_size_reg <= cur_size_next;
        status_reg   <= status_next;
        base_reg     <= base_next;
        m_status_reg <= m_status_next;
        m_base_reg   <= m_base_next;
    end

endmodule

// ===== test/ffsa_checker.sv =====
`timescale 1ns / 1ps

module ffsa_checker
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int MEM_UNITS    = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending_results
);

    typedef struct {
        status_t           status;
        logic [BASE_O_W-1:0] base;
    } grant_t;

    logic [UNIT_W-1:0]  tbl_base  [MAX_SEGMENTS];
    logic [UNIT_W-1:0]  tbl_size  [MAX_SEGMENTS];
    logic [OWNER_W-1:0] tbl_owner [MAX_SEGMENTS];
    logic               tbl_used  [MAX_SEGMENTS];
    int                 seg_total;
    logic [UNIT_W-1:0]  mem_units;
    grant_t             grant_queue[$];

    assign pending_results = grant_queue.size();

    function automatic void rebuild_table();
        for (int k = 0; k < MAX_SEGMENTS; k++) begin
            tbl_base[k] = '0; tbl_size[k] = '0; tbl_owner[k] = '0; tbl_used[k] = 1'b0;
        end
        tbl_size[0] = mem_units;
        seg_total = 1;
    endfunction

    function automatic void close_gap(int pos);
        tbl_size[pos] = tbl_size[pos] + tbl_size[pos+1];
        for (int k = pos + 1; k < seg_total - 1; k++) begin
            tbl_base[k] = tbl_base[k+1]; tbl_size[k] = tbl_size[k+1];
            tbl_owner[k] = tbl_owner[k+1]; tbl_used[k] = tbl_used[k+1];
        end
        seg_total--;
        tbl_base[seg_total] = '0; tbl_size[seg_total] = '0;
        tbl_owner[seg_total] = '0; tbl_used[seg_total] = 1'b0;
    endfunction

    function automatic grant_t predict_grant(logic act, logic [OWNER_W-1:0] who,
                                             logic [REQ_W-1:0] req);
        grant_t g;
        logic [UNIT_W-1:0] base;
        g.status = (act == ACT_ALLOC) ? ST_NO_SPACE : ST_NOT_FOUND;
        base = '0;
        for (int i = 0; i < seg_total; i++) begin
            if (act == ACT_ALLOC && !tbl_used[i] && tbl_size[i] >= req) begin
                if (tbl_size[i] != req) begin
                    if (seg_total >= MAX_SEGMENTS) begin
                        g.status = ST_TABLE_FULL;
                        break;
                    end
                    for (int k = seg_total; k > i + 1; k--) begin
                        tbl_base[k] = tbl_base[k-1]; tbl_size[k] = tbl_size[k-1];
                        tbl_owner[k] = tbl_owner[k-1]; tbl_used[k] = tbl_used[k-1];
                    end
                    seg_total++;
                    tbl_base[i+1] = tbl_base[i] + req;
                    tbl_size[i+1] = tbl_size[i] - req;
                    tbl_owner[i+1] = '0;
                    tbl_used[i+1] = 1'b0;
                    tbl_size[i] = req;
                end
                tbl_used[i] = 1'b1;
                tbl_owner[i] = who;
                g.status = ST_OK;
                base = tbl_base[i];
                break;
            end
            if (act == ACT_FREE && tbl_used[i] && tbl_owner[i] == who) begin
                tbl_used[i] = 1'b0;
                tbl_owner[i] = '0;
                base = tbl_base[i];
                g.status = ST_OK;
                if (i + 1 < seg_total && !tbl_used[i+1]) close_gap(i);
                if (i > 0 && !tbl_used[i-1]) close_gap(i - 1);
                break;
            end
        end
        g.base = (g.status == ST_OK) ? base[BASE_O_W-1:0] : '0;
        return g;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        grant_t exp_g;
        logic [9:0] v;
        if (!aresetn) begin
            mem_units = (MEM_UNITS < 512) ? UNIT_W'(MEM_UNITS) : UNIT_W'(512);
            rebuild_table();
            grant_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                v = cfg_wr_data;
                if (v == 0) v = 10'd1;
                if (v > MEM_UNITS) v = 10'(MEM_UNITS);
                mem_units = v;
                rebuild_table();
            end
            if (s_tvalid && s_tready)
                grant_queue.push_back(predict_grant(s_tuser, s_tdata[15:0],
                                                    s_tdata[23:16]));
            if (m_tvalid && m_tready) begin
                if (grant_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    exp_g = grant_queue.pop_front();
                    if (m_tdata[1:0] !== exp_g.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_tdata[1:0], exp_g.status));
                    if (m_tdata[10:2] !== exp_g.base)
                        report_mismatch($sformatf("base %0d, want %0d",
                                                  m_tdata[10:2], exp_g.base));
                end
            end
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb
    import ffsa_pkg::*;
;

    // Covers the worst-case handling of one transaction
    localparam int DRAIN_CYCLES = 300;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [9:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [15:0] owner_id, [23:16] request_size
    logic        s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [1:0] status, [10:2] base_address
    int          fail_count;
    int          pending_results;
    bit          hold_off;  // long receiver stall requested by the stimulus
    bit          rx_random; // receiver stall pattern enabled

    first_fit_segment_allocator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    ffsa_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: bursty stall pattern, plus one long hold-off on request
    initial begin
        int run_len;
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (2000) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!rx_random) begin
                m_tready <= 1'b1;
            end else begin
                run_len = $urandom_range(1, 12);
                m_tready <= $urandom_range(0, 2) != 0;
                repeat (run_len - 1) @(posedge aclk);
            end
        end
    end

    // Offer one transaction; hold it until accepted, with an optional idle gap before
    task automatic send_item(logic act, logic [15:0] who, logic [7:0] req, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {req, who};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid, drain every expected result, let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mem_size(logic [9:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        repeat (3) @(posedge aclk);
    endtask

    // Burst-shaped gap: mostly back to back, sometimes a pause
    function automatic int next_gap(ref int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 20);
        return $urandom_range(0, 1) ? $urandom_range(1, 40) : 0;
    endfunction

    initial begin
        int burst_left;
        logic [15:0] owner_pool [8];
        logic [15:0] who;
        logic [7:0]  req;
        logic        act;
        burst_left = 0;
        hold_off   = 1'b0;
        rx_random  = 1'b0;
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_wr_data = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        // Directed: zero request, exact fit, no space, unknown owner, merges
        send_item(ACT_ALLOC, 16'h0001, 8'd0, 0);
        send_item(ACT_ALLOC, 16'hFFFF, 8'd255, 0);
        send_item(ACT_ALLOC, 16'h0002, 8'd255, 0);
        send_item(ACT_ALLOC, 16'h0003, 8'd2, 0);     // exact fit of remaining 2
        send_item(ACT_ALLOC, 16'h0004, 8'd1, 0);     // no space
        send_item(ACT_FREE,  16'h1234, 8'hFF, 0);    // unknown owner
        send_item(ACT_FREE,  16'hFFFF, 8'd0, 0);
        send_item(ACT_FREE,  16'h0003, 8'd0, 0);     // no merge: the segment below is still used
        send_item(ACT_ALLOC, 16'h0001, 8'd10, 0);    // duplicate owner
        send_item(ACT_FREE,  16'h0001, 8'd0, 0);     // releases lowest one
        send_item(ACT_FREE,  16'h0001, 8'd0, 0);
        send_item(ACT_FREE,  16'h0002, 8'd0, 0);
        send_item(ACT_FREE,  16'h0001, 8'd0, 0);
        wait_idle();

        // Table full: 1-unit allocations until the table runs out of slots
        write_mem_size(10'd300);
        for (int k = 0; k < 66; k++) send_item(ACT_ALLOC, 16'(k), 8'd1, 0);
        wait_idle();
        write_mem_size(10'd0);          // taken as one unit
        send_item(ACT_ALLOC, 16'h0005, 8'd1, 0);
        send_item(ACT_ALLOC, 16'h0006, 8'd0, 0);
        wait_idle();
        write_mem_size(10'h3FF);        // saturates to MEM_UNITS

        // Random part; a long receiver hold-off early on so the input stalls
        rx_random = 1'b1;
        for (int k = 0; k < 8; k++) owner_pool[k] = 16'($urandom_range(0, 65535));
        for (int n = 0; n < 1850; n++) begin
            if (n == 100) hold_off = 1'b1;
            if (n % 400 == 399) begin
                wait_idle();
                case ((n / 400) % 4)
                    0: write_mem_size(10'd1);
                    1: write_mem_size(10'($urandom_range(16, 511)));
                    2: write_mem_size(10'd512);
                    default: write_mem_size(10'($urandom_range(0, 1023)));
                endcase
            end
            if (n % 250 == 200) wait_idle();
            act = $urandom_range(0, 99) < 45;
            who = $urandom_range(0, 15) == 0 ? 16'($urandom_range(0, 65535))
                                             : owner_pool[$urandom_range(0, 7)];
            case ($urandom_range(0, 3))
                0: req = 8'($urandom_range(0, 255));
                1: req = 8'($urandom_range(0, 4));
                default: req = 8'($urandom_range(1, 40));
            endcase
            send_item(act, who, req, next_gap(burst_left));
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[first_fit_segment_allocator_core] OK");
        else
            $display("[first_fit_segment_allocator_core] ERROR");
        $finish;
    end

    // Give up long after the slowest correct run would have finished
    initial begin
        #60ms;
        $display("[first_fit_segment_allocator_core] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ffsa_pkg.sv
rtl/core/ffsa_ram.sv
rtl/core/first_fit_segment_allocator_core.sv
test/ffsa_checker.sv
test/tb.sv
